// File: rtl/core/fust_pkg.sv
`default_nettype none

package fust_pkg;

  // Symbol alphabet. The alphabet spans the whole symbol code space.
  localparam int SYM_W         = 8;
  localparam int ALPHABET_SIZE = 1 << SYM_W;
  localparam int CNT_AW        = $clog2(ALPHABET_SIZE);
  localparam int CNT_W         = 2;

  // Order queue of first occurrences.
  localparam int QUEUE_DEPTH = 256;
  localparam int Q_AW        = $clog2(QUEUE_DEPTH);
  localparam int FILL_W      = Q_AW + 1;

  // Saturating occurrence counts.
  localparam logic [CNT_W-1:0] CNT_NONE = 2'd0;
  localparam logic [CNT_W-1:0] CNT_ONCE = 2'd1;
  localparam logic [CNT_W-1:0] CNT_MANY = 2'd2;

  typedef struct packed {
    logic              clear;
    logic              rd_en;
    logic [CNT_AW-1:0] rd_addr;
    logic              wr_en;
    logic [CNT_AW-1:0] wr_addr;
    logic [CNT_W-1:0]  wr_data;
  } cnt_req_t;

  typedef struct packed {
    logic             we;
    logic [Q_AW-1:0]  waddr;
    logic [SYM_W-1:0] wdata;
    logic             re;
    logic [Q_AW-1:0]  raddr;
  } q_req_t;

  typedef struct packed {
    logic             found;
    logic [SYM_W-1:0] sym;
  } result_t;

  function automatic logic [Q_AW-1:0] q_ptr_inc(input logic [Q_AW-1:0] p);
    return (p == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/fust_ram.sv
`default_nettype none

module fust_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/fust_cnt_store.sv
`default_nettype none

module fust_cnt_store
  import fust_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cnt_req_t         req,
  output logic      [CNT_W-1:0] count
);

  logic [ALPHABET_SIZE-1:0] valid;
  logic [CNT_AW-1:0]        rd_addr;
  logic [CNT_W-1:0]         rdata;

  fust_ram #(
    .WIDTH(CNT_W),
    .DEPTH(ALPHABET_SIZE)
  ) u_cnt_ram (
    .clk  (clk),
    .we   (req.wr_en),
    .waddr(req.wr_addr),
    .wdata(req.wr_data),
    .re   (req.rd_en),
    .raddr(req.rd_addr),
    .rdata(rdata)
  );

  // A count whose valid bit is clear reads as zero, so a new string needs no sweep.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.clear) begin
      valid <= '0;
    end else if (req.wr_en) begin
      valid[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_addr <= req.rd_addr;
    end
  end

  assign count = valid[rd_addr] ? rdata : CNT_NONE;

endmodule

`default_nettype wire

// File: rtl/core/fust_ctrl.sv
`default_nettype none

module fust_ctrl
  import fust_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [SYM_W-1:0] symbol,
  input  wire logic             first,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             slot_free,
  output logic                  load,
  output result_t               res,
  output cnt_req_t              cnt_req,
  input  wire logic [CNT_W-1:0] cnt,
  output q_req_t                q_req,
  input  wire logic [SYM_W-1:0] q_rdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_DRC  = 3'd2;
  localparam logic [2:0] S_DRT  = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;

  logic [2:0]        state, state_next;
  logic [SYM_W-1:0]  sym, sym_next;
  logic [Q_AW-1:0]   head, head_next;
  logic [Q_AW-1:0]   tail, tail_next;
  logic [FILL_W-1:0] fill, fill_next;
  logic [SYM_W-1:0]  head_sym, head_sym_next;
  logic              done;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next    = state;
    sym_next      = sym;
    head_next     = head;
    tail_next     = tail;
    fill_next     = fill;
    head_sym_next = head_sym;
    done          = 1'b0;
    load          = 1'b0;
    cnt_req       = '0;
    q_req         = '0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          sym_next        = symbol;
          cnt_req.rd_en   = 1'b1;
          cnt_req.rd_addr = CNT_AW'(symbol);
          if (first) begin
            cnt_req.clear = 1'b1;
            head_next     = '0;
            tail_next     = '0;
            fill_next     = '0;
          end
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        cnt_req.wr_en   = 1'b1;
        cnt_req.wr_addr = CNT_AW'(sym);
        if (cnt == CNT_NONE) begin
          cnt_req.wr_data = CNT_ONCE;
          if (fill < FILL_W'(QUEUE_DEPTH)) begin
            q_req.we    = 1'b1;
            q_req.waddr = tail;
            q_req.wdata = sym;
            tail_next   = q_ptr_inc(tail);
            fill_next   = fill + 1'b1;
            if (fill == '0) begin
              head_sym_next = sym;
            end
          end
          done = 1'b1;
        end else begin
          cnt_req.wr_data = CNT_MANY;
          if (fill != '0 && head_sym == sym) begin
            // The head just became a repeat: drop it and look at the next entry.
            head_next = q_ptr_inc(head);
            fill_next = fill - 1'b1;
            if (fill_next == '0) begin
              done = 1'b1;
            end else begin
              q_req.re    = 1'b1;
              q_req.raddr = head_next;
              state_next  = S_DRC;
            end
          end else begin
            done = 1'b1;
          end
        end
      end
      S_DRC: begin
        // The queue data now holds the head entry; keep it before the read of
        // the following entry replaces it.
        head_sym_next   = q_rdata;
        cnt_req.rd_en   = 1'b1;
        cnt_req.rd_addr = CNT_AW'(q_rdata);
        q_req.re        = 1'b1;
        q_req.raddr     = q_ptr_inc(head);
        state_next      = S_DRT;
      end
      S_DRT: begin
        if (cnt > CNT_ONCE) begin
          head_next = q_ptr_inc(head);
          fill_next = fill - 1'b1;
          if (fill_next == '0) begin
            done = 1'b1;
          end else begin
            state_next = S_DRC;
          end
        end else begin
          done = 1'b1;
        end
      end
      S_WAIT: begin
        done = 1'b1;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (done) begin
      if (slot_free) begin
        load       = 1'b1;
        state_next = S_IDLE;
      end else begin
        state_next = S_WAIT;
      end
    end

    res.found = (fill_next != '0);
    res.sym   = res.found ? head_sym_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      tail  <= '0;
      fill  <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      fill  <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    sym      <= sym_next;
    head_sym <= head_sym_next;
  end

endmodule

`default_nettype wire

// File: rtl/core/first_unique_symbol_tracker.sv
// First unique symbol tracker.
//
// The input channel (in_valid, in_stall, symbol, first) carries one request per
// symbol of a stream. A request with first set starts a new string and forgets
// all earlier symbols before its own symbol is counted. The output channel
// (out_valid, out_stall, found, unique_symbol) returns exactly one result per
// request, in order: the earliest symbol of the current string seen exactly
// once so far, or found low with unique_symbol zero when there is none.
//
// A request first reads the symbol's count from the count memory, then writes
// it back and enqueues the symbol on its first occurrence. Each queued symbol
// dropped from the head because it has repeated, unless the queue is then
// empty, adds a queue read and then a count read of the next head. Every
// symbol is dropped at most once per string. The result is loaded into the
// output register once the request's last step is done and the register is
// free; until then the request waits.
//
// The output register lets the next request be accepted and processed while a
// result waits under out_stall; that request then holds until the register
// frees. Reset empties the queue and marks every count invalid at once, so the
// block accepts requests as soon as reset is released.

`default_nettype none

module first_unique_symbol_tracker
  import fust_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [SYM_W-1:0] symbol,
  input  wire logic             first,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  found,
  output logic      [SYM_W-1:0] unique_symbol
);

  cnt_req_t         cnt_req;
  logic [CNT_W-1:0] cnt;
  q_req_t           q_req;
  logic [SYM_W-1:0] q_rdata;
  result_t          res;
  logic             load;
  logic             slot_free;

  // The result slot is free when it is empty or its result leaves this cycle.
  assign slot_free = !out_valid || !out_stall;

  // Occurrence counts with one valid bit per symbol.
  fust_cnt_store u_cnt_store (
    .clk  (clk),
    .rst  (rst),
    .req  (cnt_req),
    .count(cnt)
  );

  // Queue of first occurrences, in stream order; reads may pass the tail.
  fust_ram #(
    .WIDTH(SYM_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue_ram (
    .clk  (clk),
    .we   (q_req.we),
    .waddr(q_req.waddr),
    .wdata(q_req.wdata),
    .re   (q_req.re),
    .raddr(q_req.raddr),
    .rdata(q_rdata)
  );

  // Sequencer: count update, enqueue and head drain.
  fust_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .symbol   (symbol),
    .first    (first),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .slot_free(slot_free),
    .load     (load),
    .res      (res),
    .cnt_req  (cnt_req),
    .cnt      (cnt),
    .q_req    (q_req),
    .q_rdata  (q_rdata)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      found         <= res.found;
      unique_symbol <= res.sym;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/fust_chk.sv
`default_nettype none

module fust_chk
  import fust_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_valid,
  input wire logic             in_stall,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic             found,
  input wire logic [SYM_W-1:0] unique_symbol
);

  logic [1:0] pending;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // Requests taken whose results have not left yet.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(in_acc) - 2'(out_acc);
    end
  end

  a_held_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_no_extra_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0)
    else $error("result without a pending request");

  a_bounded_pending: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more than two requests in flight");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> in_stall)
    else $error("request accepted before the previous one finished");

  a_none_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> unique_symbol == '0)
    else $error("not-found result carries a symbol");

endmodule

bind first_unique_symbol_tracker fust_chk u_fust_chk (.*);

`default_nettype wire

// File: verif/tb_first_unique_symbol_tracker.sv
`default_nettype none

// Testbench for the first unique symbol tracker.
//
// Requests go in through the valid/stall input channel. Each accepted request is
// run through a local scoreboard model: per-symbol saturating counts, valid bits
// and an arrival-order queue of first occurrences. The model works out the
// result the block must return. The result checker pops the oldest expected
// result for every handshake on the output channel and compares both fields.
//
// The run has three parts. A short directed part covers the symbol extremes,
// repeats, saturation, and new strings over live history. A full-alphabet part
// fills the order queue to its depth, then drains it from the back so that one
// request drops a long run of heads. A random part sends strings drawn from
// small symbol pools so that repeats are frequent.

module tb_first_unique_symbol_tracker;
  import fust_pkg::*;

  localparam int RANDOM_REQUESTS = 216;
  localparam int QUIET_TAIL      = 60;
  localparam int CYCLE_LIMIT     = 600000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [SYM_W-1:0] symbol = '0;
  logic             first = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             found;
  logic [SYM_W-1:0] unique_symbol;

  first_unique_symbol_tracker dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .symbol       (symbol),
    .first        (first),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .found        (found),
    .unique_symbol(unique_symbol)
  );

  // Scoreboard model state. A count only means something while its live bit
  // is set; a new string clears the live bits and the arrival queue.
  logic [CNT_W-1:0] occ_count [ALPHABET_SIZE];
  bit               count_live [ALPHABET_SIZE];
  logic [SYM_W-1:0] arrival_order [$];
  result_t          expected_results [$];

  // When idling is off, neither side inserts gaps or stalls.
  bit idle_on = 1'b1;
  int stall_left = 0;

  int errors = 0;
  int requests_sent = 0;
  int strings_started = 0;
  int results_checked = 0;
  int found_results = 0;
  int cycle_count = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Computes the result of one request and advances the model state.
  function automatic result_t predict_first_unique(input logic [SYM_W-1:0] s,
                                                   input logic new_string);
    result_t          r;
    logic [CNT_W-1:0] c;
    if (new_string) begin
      foreach (count_live[i]) count_live[i] = 1'b0;
      arrival_order.delete();
    end
    c = count_live[s] ? occ_count[s] : CNT_NONE;
    if (c == CNT_NONE) begin
      // First occurrence in this string: it joins the back of the order.
      arrival_order.push_back(s);
      occ_count[s] = CNT_ONCE;
    end else begin
      occ_count[s] = CNT_MANY;
    end
    count_live[s] = 1'b1;
    // Every queued symbol belongs to the current string, so its count is live.
    while (arrival_order.size() > 0 && occ_count[arrival_order[0]] == CNT_MANY)
      void'(arrival_order.pop_front());
    r.found = (arrival_order.size() > 0);
    r.sym   = r.found ? arrival_order[0] : '0;
    return r;
  endfunction

  // Sends one request and waits for its handshake. Valid stays high on return,
  // so back-to-back requests only change the payload; a gap lowers valid first.
  task automatic send_request(input logic [SYM_W-1:0] s, input logic new_string);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    symbol   <= s;
    first    <= new_string;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(predict_first_unique(s, new_string));
    requests_sent++;
    if (new_string) strings_started++;
  endtask

  // Hand-picked sequence. The very first request comes straight out of reset
  // without the first flag, so the reset state itself must act as an empty
  // string.
  task automatic test_directed;
    send_request(8'hA5, 1'b0);
    send_request(8'h5A, 1'b0);
    send_request(8'hA5, 1'b0);  // head repeats, 5A moves up
    send_request(8'h5A, 1'b0);  // everything repeated, nothing found
    send_request(8'h5A, 1'b0);  // third occurrence saturates the count
    send_request(8'h00, 1'b1);  // new string while history is live
    send_request(8'hFF, 1'b0);
    send_request(8'hFF, 1'b0);  // non-head repeats, head stays at 00
    send_request(8'h00, 1'b0);
    send_request(8'hA5, 1'b0);  // A5 was repeated in the old string only
    send_request(8'hA5, 1'b1);  // new string on a symbol counted before
    send_request(8'hA5, 1'b1);  // new string twice in a row
    send_request(8'hFF, 1'b0);
    send_request(8'h00, 1'b0);
    send_request(8'h80, 1'b0);
    send_request(8'h01, 1'b0);
    send_request(8'hFF, 1'b0);
    send_request(8'hA5, 1'b0);  // drops two heads at once
    send_request(8'h00, 1'b0);
    send_request(8'h80, 1'b0);
    send_request(8'h01, 1'b0);  // empty again
    send_request(8'h7F, 1'b0);  // a fresh symbol after the queue drained
  endtask

  // All 256 symbols once in random order fill the queue to its depth. Repeating
  // them from the back leaves the head alone until the last repeat, which then
  // drops the whole queue in one request.
  task automatic test_full_alphabet;
    logic [SYM_W-1:0] perm [ALPHABET_SIZE];
    logic [SYM_W-1:0] tmp;
    int               j;
    foreach (perm[i]) perm[i] = SYM_W'(i);
    for (int i = ALPHABET_SIZE - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      tmp     = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    for (int i = 0; i < ALPHABET_SIZE; i++)
      send_request(perm[i], i == 0);
    for (int i = ALPHABET_SIZE - 1; i >= 0; i--)
      send_request(perm[i], 1'b0);
  endtask

  // Random strings drawn from small pools so that repeats and head drops are
  // common, with some stray symbols from the whole code space. Most strings
  // open with the first flag; a few run on, and a few restart mid-way.
  // Idling is switched per string and is off for the last stretch.
  task automatic test_random_strings;
    logic [SYM_W-1:0] pool [16];
    logic [SYM_W-1:0] s;
    logic             nf;
    int               sent;
    int               len;
    int               pool_n;
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      idle_on = (sent < RANDOM_REQUESTS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      len     = $urandom_range(1, 40);
      pool_n  = $urandom_range(2, 16);
      foreach (pool[i]) pool[i] = SYM_W'($urandom_range(0, 255));
      for (int k = 0; k < len && sent < RANDOM_REQUESTS; k++) begin
        if ($urandom_range(0, 9) == 0)
          s = SYM_W'($urandom_range(0, 255));
        else
          s = pool[$urandom_range(0, pool_n - 1)];
        nf = (k == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 63) == 0);
        send_request(s, nf);
        sent++;
      end
    end
  endtask

  // Random output-side stall bursts while idling is on.
  always @(posedge clk) begin
    if (rst || !idle_on) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 16);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Every result handshake is matched against the oldest expected result.
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result found=%0b unique_symbol=%02h",
                 $time, found, unique_symbol);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (want.found) found_results++;
        if (found !== want.found) begin
          errors++;
          $display("%0t: found expected %0b actual %0b", $time, want.found, found);
        end
        if (unique_symbol !== want.sym) begin
          errors++;
          $display("%0t: unique_symbol expected %02h actual %02h",
                   $time, want.sym, unique_symbol);
        end
      end
    end
  end

  // Watchdog. The limit sits far above the slowest legal run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding",
               $time, expected_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    foreach (count_live[i]) count_live[i] = 1'b0;
    foreach (occ_count[i]) occ_count[i] = CNT_NONE;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_full_alphabet();
    test_random_strings();
    in_valid <= 1'b0;

    // Drain the remaining results, then keep the clock running idle in case the
    // block emits something it should not.
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d requests in %0d marked strings; checked %0d results,",
             requests_sent, strings_started, results_checked);
    $display("%0d of which reported a unique symbol.", found_results);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
rtl/core/fust_pkg.sv
rtl/core/fust_ram.sv
rtl/core/fust_cnt_store.sv
rtl/core/fust_ctrl.sv
rtl/core/first_unique_symbol_tracker.sv
rtl/core/fust_chk.sv
verif/tb_first_unique_symbol_tracker.sv
